[rtl/lsw_pkg.sv]
// Shared types, codes and constants of the learning switch decision block.
`default_nettype none

package lsw_pkg;

  localparam int unsigned PortsDefault        = 8;
  localparam int unsigned TableEntriesDefault = 256;
  localparam int unsigned CmdQueueDepth       = 2;
  localparam int unsigned ResQueueDepth       = 2;
  localparam int unsigned PortMaskW           = 8;
  localparam int unsigned CfgIdxW             = 1;
  localparam int unsigned CfgDataW            = 16;

  localparam logic [CfgIdxW-1:0] CfgSwitchId      = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgControlPeriod = 1'b1;

  localparam logic [7:0]  SwitchIdReset      = 8'd0;
  localparam logic [15:0] ControlPeriodReset = 16'd10;

  localparam logic [1:0] ActNone    = 2'd0;
  localparam logic [1:0] ActForward = 2'd1;
  localparam logic [1:0] ActFlood   = 2'd2;
  localparam logic [1:0] ActControl = 2'd3;

  localparam logic [1:0] SndHost   = 2'd1;
  localparam logic [1:0] SndSwitch = 2'd2;

  typedef enum logic [1:0] {
    OpTick = 2'd0,
    OpCtrl = 2'd1,
    OpData = 2'd2,
    OpDrop = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] in_port;
    logic [7:0] src;
    logic [7:0] dst;
    logic [1:0] sender_type;
    logic [7:0] adv_root;
    logic [7:0] adv_dist;
    logic       sender_child;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [2:0]           out_port;
    logic [PortMaskW-1:0] port_mask;
    logic [7:0]           ctl_root;
    logic [7:0]           ctl_dist;
    logic [PortMaskW-1:0] child_mask;
  } result_t;

  function automatic logic [PortMaskW-1:0] all_ports(int unsigned ports);
    logic [PortMaskW-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < PortMaskW; i++) begin
      m[i] = (i < ports);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/lsw_fifo.sv]
// Small register queue used between the block's parts and at its result side.
`default_nettype none

module lsw_fifo #(
  parameter type         T     = logic [7:0],
  parameter int unsigned DEPTH = 2
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  wire T data_i,
  output logic full_o,
  input  wire  pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/lsw_front.sv]
// Front part: accepts items, classifies them and queues them for the back part.
`default_nettype none

module lsw_front #(
  parameter int unsigned PORTS = lsw_pkg::PortsDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push,
  output logic              full,
  input  wire               kind_i,
  input  wire  [2:0]        in_port_i,
  input  wire  [7:0]        pkt_src_i,
  input  wire  [7:0]        pkt_dst_i,
  input  wire               is_control_i,
  input  wire  [1:0]        sender_type_i,
  input  wire  [7:0]        adv_root_i,
  input  wire  [7:0]        adv_dist_i,
  input  wire               sender_child_i,
  output lsw_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  wire               cmd_pop_i
);

  lsw_pkg::cmd_t cmd;
  logic          cmd_empty;

  always_comb begin
    cmd.in_port      = in_port_i;
    cmd.src          = pkt_src_i;
    cmd.dst          = pkt_dst_i;
    cmd.sender_type  = sender_type_i;
    cmd.adv_root     = adv_root_i;
    cmd.adv_dist     = adv_dist_i;
    cmd.sender_child = sender_child_i;
    if (!kind_i) begin
      cmd.op = lsw_pkg::OpTick;
    end else if (32'(in_port_i) >= 32'(PORTS)) begin
      cmd.op = lsw_pkg::OpDrop;
    end else if (is_control_i) begin
      cmd.op = lsw_pkg::OpCtrl;
    end else begin
      cmd.op = lsw_pkg::OpData;
    end
  end

  lsw_fifo #(
    .T     (lsw_pkg::cmd_t),
    .DEPTH (lsw_pkg::CmdQueueDepth)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

`default_nettype wire

[rtl/lsw_back.sv]
// Back part: table lookup, root election, tree mask and control timer.
`default_nettype none

module lsw_back #(
  parameter int unsigned PORTS         = lsw_pkg::PortsDefault,
  parameter int unsigned TABLE_ENTRIES = lsw_pkg::TableEntriesDefault
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [lsw_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  [lsw_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  wire lsw_pkg::cmd_t                 cmd_i,
  input  wire                                cmd_valid_i,
  output logic                               cmd_pop_o,
  output lsw_pkg::result_t                   res_o,
  output logic                               res_push_o,
  input  wire                                res_full_i
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [8:0] TableLimit = 9'(TABLE_ENTRIES);
  localparam logic [lsw_pkg::PortMaskW-1:0] AllPorts = lsw_pkg::all_ports(PORTS);

  // read stage
  logic          s1_valid_q;
  lsw_pkg::cmd_t s1_cmd_q;
  logic          fwd_hit_q;
  logic [2:0]    fwd_port_q;
  logic [2:0]    rd_port_q;
  logic [2:0]    entry_port_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid_q;

  // switch state
  logic [15:0] period_q, period_d;
  logic [7:0]  root_id_q, root_id_d;
  logic [7:0]  root_dist_q, root_dist_d;
  logic        parent_known_q, parent_known_d;
  logic [2:0]  parent_port_q, parent_port_d;
  logic [lsw_pkg::PortMaskW-1:0] tree_q, tree_d;
  logic [15:0] tick_q, tick_d;

  logic            advance, complete;
  logic [IdxW-1:0] rd_idx, src_idx, dst_idx;
  logic            src_ok, dst_ok, dst_hit, learn_en;
  logic [15:0]     tick_inc;
  logic [8:0]      cand;
  logic [lsw_pkg::PortMaskW-1:0] in_bit;

  assign advance    = !s1_valid_q || !res_full_i;
  assign complete   = s1_valid_q && !res_full_i;
  assign cmd_pop_o  = cmd_valid_i && advance;
  assign res_push_o = complete;

  assign rd_idx   = cmd_i.dst[IdxW-1:0];
  assign src_idx  = s1_cmd_q.src[IdxW-1:0];
  assign dst_idx  = s1_cmd_q.dst[IdxW-1:0];
  assign src_ok   = ({1'b0, s1_cmd_q.src} < TableLimit);
  assign dst_ok   = ({1'b0, s1_cmd_q.dst} < TableLimit);
  assign dst_hit  = dst_ok && entry_valid_q[dst_idx];
  assign learn_en = complete && src_ok && !entry_valid_q[src_idx] &&
                    ((s1_cmd_q.op == lsw_pkg::OpCtrl) || (s1_cmd_q.op == lsw_pkg::OpData));

  assign tick_inc = tick_q + 16'd1;
  assign cand     = {1'b0, s1_cmd_q.adv_dist} + 9'd1;
  assign in_bit   = lsw_pkg::PortMaskW'(1) << s1_cmd_q.in_port;

  always_comb begin
    period_d       = period_q;
    root_id_d      = root_id_q;
    root_dist_d    = root_dist_q;
    parent_known_d = parent_known_q;
    parent_port_d  = parent_port_q;
    tree_d         = tree_q;
    tick_d         = tick_q;
    res_o          = '0;
    res_o.action   = lsw_pkg::ActNone;

    if (complete) begin
      unique case (s1_cmd_q.op)
        lsw_pkg::OpTick: begin
          if (tick_inc >= period_q) begin
            tick_d           = '0;
            res_o.action     = lsw_pkg::ActControl;
            res_o.port_mask  = AllPorts;
            res_o.ctl_root   = root_id_q;
            res_o.ctl_dist   = root_dist_q;
            res_o.child_mask = parent_known_q ?
                               ((lsw_pkg::PortMaskW'(1) << parent_port_q) & AllPorts) : '0;
          end else begin
            tick_d = tick_inc;
          end
        end
        lsw_pkg::OpCtrl: begin
          if (s1_cmd_q.sender_type == lsw_pkg::SndSwitch) begin
            if (s1_cmd_q.adv_root < root_id_q) begin
              root_id_d      = s1_cmd_q.adv_root;
              parent_known_d = 1'b1;
              parent_port_d  = s1_cmd_q.in_port;
              root_dist_d    = cand[8] ? 8'hFF : cand[7:0];
            end else if (s1_cmd_q.adv_root == root_id_q && {1'b0, root_dist_q} > cand) begin
              parent_known_d = 1'b1;
              parent_port_d  = s1_cmd_q.in_port;
              root_dist_d    = cand[7:0];
            end
          end
          if (s1_cmd_q.sender_type == lsw_pkg::SndHost) begin
            tree_d = tree_q | in_bit;
          end else if (s1_cmd_q.sender_type == lsw_pkg::SndSwitch &&
                       ((parent_known_d && parent_port_d == s1_cmd_q.in_port) ||
                        s1_cmd_q.sender_child)) begin
            tree_d = tree_q | in_bit;
          end else begin
            tree_d = tree_q & ~in_bit;
          end
        end
        lsw_pkg::OpData: begin
          if (dst_hit) begin
            res_o.action   = lsw_pkg::ActForward;
            res_o.out_port = fwd_hit_q ? fwd_port_q : rd_port_q;
          end else begin
            res_o.action    = lsw_pkg::ActFlood;
            res_o.port_mask = (parent_known_q ? tree_q : AllPorts) & AllPorts & ~in_bit;
          end
        end
        lsw_pkg::OpDrop: begin
          res_o.action = lsw_pkg::ActNone;
        end
      endcase
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsw_pkg::CfgSwitchId: begin
          root_id_d      = cfg_wdata_i[7:0];
          root_dist_d    = '0;
          parent_known_d = 1'b0;
          parent_port_d  = '0;
        end
        lsw_pkg::CfgControlPeriod: begin
          period_d = cfg_wdata_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      period_q       <= lsw_pkg::ControlPeriodReset;
      root_id_q      <= lsw_pkg::SwitchIdReset;
      root_dist_q    <= '0;
      parent_known_q <= 1'b0;
      parent_port_q  <= '0;
      tree_q         <= '0;
      tick_q         <= '0;
      entry_valid_q  <= '0;
    end else begin
      if (advance) begin
        s1_valid_q <= cmd_pop_o;
      end
      period_q       <= period_d;
      root_id_q      <= root_id_d;
      root_dist_q    <= root_dist_d;
      parent_known_q <= parent_known_d;
      parent_port_q  <= parent_port_d;
      tree_q         <= tree_d;
      tick_q         <= tick_d;
      if (learn_en) begin
        entry_valid_q[src_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s1_cmd_q   <= cmd_i;
      fwd_hit_q  <= learn_en && (src_idx == rd_idx);
      fwd_port_q <= s1_cmd_q.in_port;
    end
  end

  always_ff @(posedge clk_i) begin
    if (learn_en) begin
      entry_port_mem[src_idx] <= s1_cmd_q.in_port;
    end
    if (cmd_pop_o) begin
      rd_port_q <= entry_port_mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

[rtl/learning_switch_with_tree_election_unit.sv]
// Learning switch port decision with spanning-tree root election, top level.
// Path: command queue, lookup stage, result queue; a full result queue stalls lookup.
// Throughput: one item per cycle unless stalled; lookup is one registered memory read.
// Reset: election, tree and timer state cleared, all table valid bits cleared at once;
// items are taken from the first cycle after reset.
`default_nettype none

module learning_switch_with_tree_election_unit #(
  parameter int unsigned PORTS         = lsw_pkg::PortsDefault,
  parameter int unsigned TABLE_ENTRIES = lsw_pkg::TableEntriesDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [lsw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [lsw_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire                          push,
  output logic                         full,
  input  wire                          kind_i,
  input  wire  [2:0]                   in_port_i,
  input  wire  [7:0]                   pkt_src_i,
  input  wire  [7:0]                   pkt_dst_i,
  input  wire                          is_control_i,
  input  wire  [1:0]                   sender_type_i,
  input  wire  [7:0]                   adv_root_i,
  input  wire  [7:0]                   adv_dist_i,
  input  wire                          sender_child_i,
  output logic                         empty,
  input  wire                          pop,
  output logic [1:0]                   action_o,
  output logic [2:0]                   out_port_o,
  output logic [7:0]                   port_mask_o,
  output logic [7:0]                   ctl_root_o,
  output logic [7:0]                   ctl_dist_o,
  output logic [7:0]                   child_mask_o
);

  lsw_pkg::cmd_t    cmd;
  logic             cmd_valid, cmd_pop;
  lsw_pkg::result_t res_in, res_out;
  logic             res_push, res_full;

  lsw_front #(
    .PORTS (PORTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .in_port_i      (in_port_i),
    .pkt_src_i      (pkt_src_i),
    .pkt_dst_i      (pkt_dst_i),
    .is_control_i   (is_control_i),
    .sender_type_i  (sender_type_i),
    .adv_root_i     (adv_root_i),
    .adv_dist_i     (adv_dist_i),
    .sender_child_i (sender_child_i),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop)
  );

  lsw_back #(
    .PORTS         (PORTS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  lsw_fifo #(
    .T     (lsw_pkg::result_t),
    .DEPTH (lsw_pkg::ResQueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign action_o     = res_out.action;
  assign out_port_o   = res_out.out_port;
  assign port_mask_o  = res_out.port_mask;
  assign ctl_root_o   = res_out.ctl_root;
  assign ctl_dist_o   = res_out.ctl_dist;
  assign child_mask_o = res_out.child_mask;

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the learning switch decision block with a scoreboard class.
`timescale 1ns / 100ps

module tb;

  localparam logic       KindTick     = 1'b0;
  localparam logic       KindPacket   = 1'b1;
  localparam logic [1:0] SndOther     = 2'd0;
  localparam logic [1:0] SndUndefined = 2'd3;
  localparam logic [7:0] AllPorts     = 8'hFF;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct packed {
    logic       kind;
    logic [2:0] in_port;
    logic [7:0] src;
    logic [7:0] dst;
    logic       is_control;
    logic [1:0] sender_type;
    logic [7:0] adv_root;
    logic [7:0] adv_dist;
    logic       sender_child;
  } pkt_t;

  class decision_board;
    logic [7:0]  switch_id;
    logic [15:0] period;
    logic [7:0]  root_id;
    logic [7:0]  root_dist;
    bit          parent_known;
    logic [2:0]  parent_port;
    logic [7:0]  tree_ports;
    logic [15:0] tick_count;
    bit          learned [256];
    logic [2:0]  learned_port [256];
    lsw_pkg::result_t decisions_due [$];
    int          errors;

    function new();
      switch_id    = lsw_pkg::SwitchIdReset;
      period       = lsw_pkg::ControlPeriodReset;
      root_id      = lsw_pkg::SwitchIdReset;
      root_dist    = '0;
      parent_known = 1'b0;
      parent_port  = '0;
      tree_ports   = '0;
      tick_count   = '0;
      errors       = 0;
      foreach (learned[i]) learned[i] = 1'b0;
    endfunction

    function void configure(logic [lsw_pkg::CfgIdxW-1:0] idx,
                            logic [lsw_pkg::CfgDataW-1:0] data);
      if (idx == lsw_pkg::CfgSwitchId) begin
        switch_id    = data[7:0];
        root_id      = data[7:0];
        root_dist    = '0;
        parent_known = 1'b0;
        parent_port  = '0;
      end else if (idx == lsw_pkg::CfgControlPeriod) begin
        period = data;
      end
    endfunction

    function void learn_source(logic [7:0] src, logic [2:0] port);
      if (!learned[src]) begin
        learned[src]      = 1'b1;
        learned_port[src] = port;
      end
    endfunction

    function void note_item(pkt_t p);
      lsw_pkg::result_t r;
      logic [8:0] cand;
      logic [7:0] bit_m;
      r = '0;
      bit_m = 8'd1 << p.in_port;
      if (p.kind == KindTick) begin
        tick_count = tick_count + 16'd1;
        if (tick_count >= period) begin
          tick_count   = '0;
          r.action     = lsw_pkg::ActControl;
          r.port_mask  = AllPorts;
          r.ctl_root   = root_id;
          r.ctl_dist   = root_dist;
          r.child_mask = parent_known ? (8'd1 << parent_port) : 8'd0;
        end
      end else if (p.is_control) begin
        cand = {1'b0, p.adv_dist} + 9'd1;
        if (p.sender_type == lsw_pkg::SndSwitch) begin
          if (p.adv_root < root_id) begin
            root_id      = p.adv_root;
            parent_known = 1'b1;
            parent_port  = p.in_port;
            root_dist    = cand[8] ? 8'hFF : cand[7:0];
          end else if (p.adv_root == root_id && {1'b0, root_dist} > cand) begin
            parent_known = 1'b1;
            parent_port  = p.in_port;
            root_dist    = cand[7:0];
          end
        end
        if (p.sender_type == lsw_pkg::SndHost) begin
          tree_ports |= bit_m;
        end else if (p.sender_type == lsw_pkg::SndSwitch &&
                     ((parent_known && parent_port == p.in_port) || p.sender_child)) begin
          tree_ports |= bit_m;
        end else begin
          tree_ports &= ~bit_m;
        end
        learn_source(p.src, p.in_port);
      end else begin
        if (learned[p.dst]) begin
          r.action   = lsw_pkg::ActForward;
          r.out_port = learned_port[p.dst];
        end else begin
          r.action    = lsw_pkg::ActFlood;
          r.port_mask = (parent_known ? tree_ports : AllPorts) & ~bit_m;
        end
        learn_source(p.src, p.in_port);
      end
      decisions_due.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        if (errors < 100)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_decision(lsw_pkg::result_t got);
      lsw_pkg::result_t want;
      if (decisions_due.size() == 0) begin
        if (errors < 100)
          $display("%0t: result beat with none due, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = decisions_due.pop_front();
      compare_field("action", want.action, got.action);
      compare_field("out_port", want.out_port, got.out_port);
      compare_field("port_mask", want.port_mask, got.port_mask);
      compare_field("ctl_root", want.ctl_root, got.ctl_root);
      compare_field("ctl_dist", want.ctl_dist, got.ctl_dist);
      compare_field("child_mask", want.child_mask, got.child_mask);
    endfunction

    function int pending();
      return decisions_due.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [lsw_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [lsw_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                         push;
  logic                         full;
  logic                         kind_i;
  logic [2:0]                   in_port_i;
  logic [7:0]                   pkt_src_i;
  logic [7:0]                   pkt_dst_i;
  logic                         is_control_i;
  logic [1:0]                   sender_type_i;
  logic [7:0]                   adv_root_i;
  logic [7:0]                   adv_dist_i;
  logic                         sender_child_i;
  logic                         empty;
  logic                         pop;
  logic [1:0]                   action_o;
  logic [2:0]                   out_port_o;
  logic [7:0]                   port_mask_o;
  logic [7:0]                   ctl_root_o;
  logic [7:0]                   ctl_dist_o;
  logic [7:0]                   child_mask_o;

  decision_board sb;
  bit            quiet   = 1'b0;
  int            tx_calm = 0;
  int            rx_calm = 0;
  int unsigned   cycles  = 0;

  learning_switch_with_tree_election_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .in_port_i      (in_port_i),
    .pkt_src_i      (pkt_src_i),
    .pkt_dst_i      (pkt_dst_i),
    .is_control_i   (is_control_i),
    .sender_type_i  (sender_type_i),
    .adv_root_i     (adv_root_i),
    .adv_dist_i     (adv_dist_i),
    .sender_child_i (sender_child_i),
    .empty          (empty),
    .pop            (pop),
    .action_o       (action_o),
    .out_port_o     (out_port_o),
    .port_mask_o    (port_mask_o),
    .ctl_root_o     (ctl_root_o),
    .ctl_dist_o     (ctl_dist_o),
    .child_mask_o   (child_mask_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** learning_switch_with_tree_election_unit: FAILED **");
      $finish;
    end
  end

  function automatic bit want_gap(inout int calm);
    if (quiet) return 1'b0;
    if (calm > 0) begin
      calm--;
      return 1'b0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = int'($urandom_range(20, 60));
      return 1'b0;
    end
    return $urandom_range(0, 3) == 0;
  endfunction

  function automatic pkt_t noise_item();
    pkt_t p;
    p = 40'({$urandom, $urandom});
    p.in_port      = 3'($urandom_range(0, 7));
    p.src          = 8'($urandom);
    p.dst          = 8'($urandom);
    p.adv_root     = 8'($urandom);
    p.adv_dist     = 8'($urandom);
    p.sender_type  = 2'($urandom_range(0, 3));
    p.sender_child = 1'($urandom_range(0, 1));
    return p;
  endfunction

  function automatic pkt_t tick_item();
    pkt_t p;
    p = noise_item();
    p.kind = KindTick;
    return p;
  endfunction

  function automatic pkt_t ctrl_item(logic [2:0] port, logic [7:0] src, logic [1:0] st,
                                     logic [7:0] root, logic [7:0] adv_d, logic child);
    pkt_t p;
    p = noise_item();
    p.kind         = KindPacket;
    p.is_control   = 1'b1;
    p.in_port      = port;
    p.src          = src;
    p.sender_type  = st;
    p.adv_root     = root;
    p.adv_dist     = adv_d;
    p.sender_child = child;
    return p;
  endfunction

  function automatic pkt_t data_item(logic [2:0] port, logic [7:0] src, logic [7:0] dst);
    pkt_t p;
    p = noise_item();
    p.kind       = KindPacket;
    p.is_control = 1'b0;
    p.in_port    = port;
    p.src        = src;
    p.dst        = dst;
    return p;
  endfunction

  function automatic logic [7:0] pick_node();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 15));
    return 8'($urandom);
  endfunction

  function automatic pkt_t rand_item();
    pkt_t p;
    int   sel;
    sel = int'($urandom_range(0, 99));
    if (sel < 20) return tick_item();
    p = data_item(3'($urandom_range(0, 7)), pick_node(), pick_node());
    if (sel < 55) begin
      p.is_control = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: p.sender_type = lsw_pkg::SndSwitch;
        6, 7:             p.sender_type = lsw_pkg::SndHost;
        8:                p.sender_type = SndOther;
        default:          p.sender_type = SndUndefined;
      endcase
      case ($urandom_range(0, 3))
        0:       p.adv_root = sb.root_id;
        1:       p.adv_root = sb.root_id - {7'd0, sb.root_id != 8'd0};
        2:       p.adv_root = sb.root_id + 8'd1;
        default: p.adv_root = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       p.adv_dist = 8'($urandom_range(0, 7));
        1:       p.adv_dist = 8'($urandom_range(254, 255));
        2:       p.adv_dist = sb.root_dist - 8'd2;
        default: p.adv_dist = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  task automatic send_item(input pkt_t p);
    if (want_gap(tx_calm)) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    push           <= 1'b1;
    kind_i         <= p.kind;
    in_port_i      <= p.in_port;
    pkt_src_i      <= p.src;
    pkt_dst_i      <= p.dst;
    is_control_i   <= p.is_control;
    sender_type_i  <= p.sender_type;
    adv_root_i     <= p.adv_root;
    adv_dist_i     <= p.adv_dist;
    sender_child_i <= p.sender_child;
    do @(posedge clk_i); while (full);
    sb.note_item(p);
  endtask

  task automatic write_cfg(input logic [lsw_pkg::CfgIdxW-1:0] idx,
                           input logic [lsw_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.configure(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] sw, input logic [15:0] period, input int count,
                           input int quiet_tail);
    logic [15:0] wd;
    wd = 16'($urandom);
    wd[7:0] = sw;
    write_cfg(lsw_pkg::CfgSwitchId, wd);
    write_cfg(lsw_pkg::CfgControlPeriod, period);
    for (int i = 0; i < count; i++) begin
      if (count - i <= quiet_tail) quiet = 1'b1;
      send_item(rand_item());
    end
    drain();
  endtask

  initial begin
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      lsw_pkg::result_t got;
      if (want_gap(rx_calm)) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.action     = action_o;
      got.out_port   = out_port_o;
      got.port_mask  = port_mask_o;
      got.ctl_root   = ctl_root_o;
      got.ctl_dist   = ctl_dist_o;
      got.child_mask = child_mask_o;
      sb.check_decision(got);
    end
  end

  initial begin
    sb = new();
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_wdata_i    <= '0;
    push           <= 1'b0;
    kind_i         <= 1'b0;
    in_port_i      <= '0;
    pkt_src_i      <= '0;
    pkt_dst_i      <= '0;
    is_control_i   <= 1'b0;
    sender_type_i  <= '0;
    adv_root_i     <= '0;
    adv_dist_i     <= '0;
    sender_child_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(lsw_pkg::CfgSwitchId, 16'hA5C8);
    write_cfg(lsw_pkg::CfgControlPeriod, 16'd3);
    send_item(data_item(3'd0, 8'h00, 8'hFF));
    send_item(data_item(3'd7, 8'hFF, 8'h00));
    repeat (3) send_item(tick_item());
    send_item(ctrl_item(3'd3, 8'h0A, lsw_pkg::SndHost, 8'hFF, 8'h00, 1'b0));
    send_item(ctrl_item(3'd5, 8'h0B, lsw_pkg::SndSwitch, 8'h32, 8'hFF, 1'b0));
    send_item(ctrl_item(3'd6, 8'h0C, lsw_pkg::SndSwitch, 8'h32, 8'hFE, 1'b0));
    send_item(ctrl_item(3'd6, 8'h0C, lsw_pkg::SndSwitch, 8'h32, 8'h0A, 1'b0));
    send_item(ctrl_item(3'd3, 8'h0D, SndOther, 8'h00, 8'h00, 1'b1));
    send_item(ctrl_item(3'd4, 8'h0E, SndUndefined, 8'h00, 8'h00, 1'b1));
    send_item(ctrl_item(3'd2, 8'h0F, lsw_pkg::SndSwitch, 8'hFF, 8'h00, 1'b1));
    send_item(ctrl_item(3'd5, 8'h10, lsw_pkg::SndSwitch, 8'hFF, 8'h00, 1'b0));
    send_item(data_item(3'd2, 8'h20, 8'h4D));
    send_item(data_item(3'd3, 8'h21, 8'h0A));
    send_item(data_item(3'd1, 8'h0A, 8'h00));
    send_item(data_item(3'd4, 8'h22, 8'h0A));
    repeat (3) send_item(tick_item());
    drain();
    write_cfg(lsw_pkg::CfgSwitchId, 16'h00FF);
    write_cfg(lsw_pkg::CfgControlPeriod, 16'd0);
    repeat (2) send_item(tick_item());
    drain();

    run_phase(8'd0, 16'd1, 150, 0);
    run_phase(8'd255, 16'hFFFF, 100, 0);
    run_phase(8'($urandom), 16'($urandom_range(2, 20)), 200, 0);
    run_phase(8'd128, 16'd0, 100, 0);
    run_phase(8'($urandom), 16'($urandom_range(1, 16)), 250, 120);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** learning_switch_with_tree_election_unit: PASSED **");
    end else begin
      $display("** learning_switch_with_tree_election_unit: FAILED **");
    end
    $finish;
  end

endmodule
